@@ hw/rtl/looping_playback_timer_top_macros.svh @@
// Assertion macros shared by the checker of the looping playback timer.
// No dependencies; included by the checker file only.
`ifndef LOOPING_PLAYBACK_TIMER_TOP_MACROS_SVH
`define LOOPING_PLAYBACK_TIMER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define LPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("looping playback timer check failed");

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("looping playback timer check failed");

// Consequent must hold in the cycle after a reset cycle.
`define LPT_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("looping playback timer reset check failed");

`endif

@@ hw/rtl/lpt_pkg.sv @@
// Package of the looping playback timer: field types, codes, register map,
// microcode enums and the control program. No dependencies.
`default_nettype none

package lpt_pkg;

    localparam int PaddrW = 5;
    typedef logic [PaddrW-1:0] t_paddr;
    typedef logic [31:0] t_pdata;
    typedef logic [2:0] t_regidx;

    typedef logic [31:0] t_time;
    typedef logic [15:0] t_speed;
    typedef logic [15:0] t_loops;
    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_wrap;

    localparam t_regidx RegClipLength = 3'd0;
    localparam t_regidx RegStartSpeed = 3'd1;
    localparam t_regidx RegStartLoops = 3'd2;
    localparam t_regidx RegLeadInSpan = 3'd3;
    localparam t_regidx RegWrapMode   = 3'd4;

    localparam t_cmd CmdTick   = 3'd0;
    localparam t_cmd CmdStart  = 3'd1;
    localparam t_cmd CmdPause  = 3'd2;
    localparam t_cmd CmdResume = 3'd3;
    localparam t_cmd CmdClear  = 3'd4;

    localparam t_wrap WrapNone = 2'd0;
    localparam t_wrap WrapOnce = 2'd1;
    localparam t_wrap WrapHold = 2'd2;
    localparam t_wrap WrapPing = 2'd3;

    localparam t_time  ClipLengthRst = 32'd0;
    localparam t_speed StartSpeedRst = 16'h0100;
    localparam t_loops StartLoopsRst = 16'd0;
    localparam t_time  LeadInSpanRst = 32'd0;
    localparam t_wrap  WrapModeRst   = WrapOnce;

    localparam t_speed SpeedMin = 16'h8000;
    localparam t_speed SpeedMax = 16'h7FFF;

    localparam int DivSteps = 33;
    typedef logic [5:0] t_cnt;
    localparam t_cnt DivLast = t_cnt'(DivSteps - 1);

    typedef struct packed {
        t_time  clip_length;
        t_speed start_speed;
        t_loops start_loops;
        t_time  lead_in_span;
        t_wrap  wrap_mode;
    } t_cfg;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_SIMPLE,
        UOP_LEAD,
        UOP_MUL,
        UOP_ADD,
        UOP_SUB,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_WRAPS,
        UOP_FINISH,
        UOP_APPLY,
        UOP_SET_SUM,
        UOP_START,
        UOP_TIME_REM,
        UOP_TIME_CLR,
        UOP_RESULT
    } t_uop;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_FIRE,
        COND_IS_START,
        COND_TICK_SKIP,
        COND_LEAD_SHORT,
        COND_SUM_LT,
        COND_DIV_MORE,
        COND_NOT_FINAL,
        COND_START_ZERO,
        COND_OUT_BUSY
    } t_cond;

    typedef logic [4:0] t_pc;

    localparam t_pc StepIdle     = 5'd0;
    localparam t_pc StepDispatch = 5'd1;
    localparam t_pc StepTickSkip = 5'd2;
    localparam t_pc StepLead     = 5'd3;
    localparam t_pc StepMul      = 5'd4;
    localparam t_pc StepAdd      = 5'd5;
    localparam t_pc StepSub      = 5'd6;
    localparam t_pc StepDivInit  = 5'd7;
    localparam t_pc StepTickDiv  = 5'd8;
    localparam t_pc StepWraps    = 5'd9;
    localparam t_pc StepCheck    = 5'd10;
    localparam t_pc StepFinish   = 5'd11;
    localparam t_pc StepApply    = 5'd12;
    localparam t_pc StepSetSum   = 5'd13;
    localparam t_pc StepStart    = 5'd14;
    localparam t_pc StepStartDiv = 5'd15;
    localparam t_pc StepTimeRem  = 5'd16;
    localparam t_pc StepTimeClr  = 5'd17;
    localparam t_pc StepOut      = 5'd18;
    localparam t_pc StepLast     = StepOut;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_cword;

    typedef struct packed {
        t_uop uop;
        logic idle;
    } t_ctl;

    typedef struct packed {
        logic no_fire;
        logic is_start;
        logic tick_skip;
        logic lead_short;
        logic sum_lt;
        logic div_more;
        logic not_final;
        logic start_zero;
        logic out_busy;
    } t_flags;

    function automatic t_cword f_rom(input t_pc pc);
        t_cword w;
        unique case (pc)
            StepIdle:     w = '{UOP_NONE,     COND_NO_FIRE,    StepIdle};
            StepDispatch: w = '{UOP_SIMPLE,   COND_IS_START,   StepStart};
            StepTickSkip: w = '{UOP_NONE,     COND_TICK_SKIP,  StepOut};
            StepLead:     w = '{UOP_LEAD,     COND_LEAD_SHORT, StepOut};
            StepMul:      w = '{UOP_MUL,      COND_NEVER,      StepIdle};
            StepAdd:      w = '{UOP_ADD,      COND_NEVER,      StepIdle};
            StepSub:      w = '{UOP_SUB,      COND_SUM_LT,     StepSetSum};
            StepDivInit:  w = '{UOP_DIV_INIT, COND_NEVER,      StepIdle};
            StepTickDiv:  w = '{UOP_DIV_STEP, COND_DIV_MORE,   StepTickDiv};
            StepWraps:    w = '{UOP_WRAPS,    COND_NEVER,      StepIdle};
            StepCheck:    w = '{UOP_NONE,     COND_NOT_FINAL,  StepApply};
            StepFinish:   w = '{UOP_FINISH,   COND_ALWAYS,     StepOut};
            StepApply:    w = '{UOP_APPLY,    COND_ALWAYS,     StepOut};
            StepSetSum:   w = '{UOP_SET_SUM,  COND_ALWAYS,     StepOut};
            StepStart:    w = '{UOP_START,    COND_START_ZERO, StepTimeClr};
            StepStartDiv: w = '{UOP_DIV_STEP, COND_DIV_MORE,   StepStartDiv};
            StepTimeRem:  w = '{UOP_TIME_REM, COND_ALWAYS,     StepOut};
            StepTimeClr:  w = '{UOP_TIME_CLR, COND_NEVER,      StepIdle};
            StepOut:      w = '{UOP_RESULT,   COND_OUT_BUSY,   StepOut};
            default:      w = '{UOP_NONE,     COND_ALWAYS,     StepIdle};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lpt_if.sv @@
// Request and result channel interfaces of the looping playback timer.
// Depends on lpt_pkg for the field types.
`default_nettype none

interface lpt_req_if;
    import lpt_pkg::*;
    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_time delta;
    logic  reset_position;
    modport source (output valid, cmd, delta, reset_position, input ready);
    modport sink (input valid, cmd, delta, reset_position, output ready);
endinterface

interface lpt_rsp_if;
    import lpt_pkg::*;
    logic   valid;
    logic   ready;
    t_time  position;
    t_time  sample_point;
    logic   is_playing;
    logic   is_loaded;
    logic   in_lead_in;
    logic   is_reversed;
    t_loops loops_remaining;
    logic   ended;
    modport source (output valid, position, sample_point, is_playing, is_loaded,
                    in_lead_in, is_reversed, loops_remaining, ended, input ready);
    modport sink (input valid, position, sample_point, is_playing, is_loaded,
                  in_lead_in, is_reversed, loops_remaining, ended, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lpt_cfg.sv @@
// APB-style configuration registers of the looping playback timer.
// Depends on lpt_pkg for the register map and reset values.
`default_nettype none

module lpt_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  lpt_pkg::t_paddr i_paddr,
    input  lpt_pkg::t_pdata i_pwdata,
    output lpt_pkg::t_pdata o_prdata,
    output logic            o_pready,
    output lpt_pkg::t_cfg   o_cfg
);
    import lpt_pkg::*;

    t_time   r_clip_length;
    t_speed  r_start_speed;
    t_loops  r_start_loops;
    t_time   r_lead_in_span;
    t_wrap   r_wrap_mode;
    t_regidx idx;
    logic    wr_en;

    assign idx      = i_paddr[PaddrW-1:2];
    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_length  <= ClipLengthRst;
            r_start_speed  <= StartSpeedRst;
            r_start_loops  <= StartLoopsRst;
            r_lead_in_span <= LeadInSpanRst;
            r_wrap_mode    <= WrapModeRst;
        end else if (wr_en) begin
            unique case (idx)
                RegClipLength: r_clip_length  <= i_pwdata;
                RegStartSpeed: r_start_speed  <= i_pwdata[15:0];
                RegStartLoops: r_start_loops  <= i_pwdata[15:0];
                RegLeadInSpan: r_lead_in_span <= i_pwdata;
                RegWrapMode:   r_wrap_mode    <= i_pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            RegClipLength: o_prdata = r_clip_length;
            RegStartSpeed: o_prdata = {16'd0, r_start_speed};
            RegStartLoops: o_prdata = {16'd0, r_start_loops};
            RegLeadInSpan: o_prdata = r_lead_in_span;
            RegWrapMode:   o_prdata = {30'd0, r_wrap_mode};
            default:       o_prdata = '0;
        endcase
    end

    assign o_cfg = '{clip_length:  r_clip_length,
                     start_speed:  r_start_speed,
                     start_loops:  r_start_loops,
                     lead_in_span: r_lead_in_span,
                     wrap_mode:    r_wrap_mode};

endmodule

`default_nettype wire

@@ hw/rtl/lpt_seq.sv @@
// Microcode sequencer of the looping playback timer: step counter, control
// program from lpt_pkg::f_rom and conditional jumps on datapath flags.
`default_nettype none

module lpt_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpt_pkg::t_flags i_flags,
    output lpt_pkg::t_ctl   o_ctl
);
    import lpt_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_cword word;
    logic   take;

    assign word = f_rom(r_pc);

    always_comb begin
        unique case (word.cond)
            COND_NEVER:      take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_NO_FIRE:    take = i_flags.no_fire;
            COND_IS_START:   take = i_flags.is_start;
            COND_TICK_SKIP:  take = i_flags.tick_skip;
            COND_LEAD_SHORT: take = i_flags.lead_short;
            COND_SUM_LT:     take = i_flags.sum_lt;
            COND_DIV_MORE:   take = i_flags.div_more;
            COND_NOT_FINAL:  take = i_flags.not_final;
            COND_START_ZERO: take = i_flags.start_zero;
            COND_OUT_BUSY:   take = i_flags.out_busy;
            default:         take = 1'b0;
        endcase
    end

    always_comb begin
        if (take) begin
            n_pc = word.target;
        end else if (r_pc == StepLast) begin
            n_pc = StepIdle;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= StepIdle;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        o_ctl.uop  = word.uop;
        o_ctl.idle = (r_pc == StepIdle);
    end

endmodule

`default_nettype wire

@@ hw/rtl/lpt_dp.sv @@
// Datapath of the looping playback timer: channel state, multiplier,
// restoring divider and result register, driven by micro-operations.
// Depends on lpt_pkg and the channel interfaces in lpt_if.sv.
`default_nettype none

module lpt_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpt_pkg::t_cfg   i_cfg,
    input  lpt_pkg::t_ctl   i_ctl,
    output lpt_pkg::t_flags o_flags,
    lpt_req_if.sink         i_req,
    lpt_rsp_if.source       o_rsp
);
    import lpt_pkg::*;

    t_cmd        r_cmd;
    t_time       r_delta;
    logic        r_rpos;

    t_time       r_time,     n_time;
    t_time       r_lead_len, n_lead_len;
    logic        r_lead_act, n_lead_act;
    logic        r_run,      n_run;
    logic        r_load,     n_load;
    logic        r_ended,    n_ended;
    t_speed      r_speed,    n_speed;
    t_loops      r_loops,    n_loops;

    logic [32:0] r_d,        n_d;
    t_time       r_adv,      n_adv;
    logic [32:0] r_sum,      n_sum;
    logic [32:0] r_rem,      n_rem;
    logic [32:0] r_dq,       n_dq;
    t_time       r_dr,       n_dr;
    t_cnt        r_cnt,      n_cnt;
    logic [33:0] r_wraps,    n_wraps;

    logic        r_ovalid;
    t_time       r_o_position;
    t_time       r_o_sample;
    logic        r_o_playing;
    logic        r_o_loaded;
    logic        r_o_lead;
    logic        r_o_rev;
    t_loops      r_o_loops;
    logic        r_o_ended;

    logic        fire;
    logic [32:0] len33;
    logic        len_zero;
    logic [15:0] mag;
    t_speed      flipped;
    t_speed      fin_speed;
    logic [48:0] prod;
    t_time       adv_sat;
    logic [33:0] lead_diff;
    logic        lead_short;
    logic [32:0] div_t;
    logic [32:0] div_sub;
    logic        div_ge;
    logic        is_final;
    t_time       sample_val;
    logic        out_busy;
    logic        out_load;

    assign i_req.ready = i_ctl.idle;
    assign fire        = i_req.valid & i_ctl.idle;

    assign len33      = {1'b0, i_cfg.clip_length};
    assign len_zero   = (i_cfg.clip_length == '0);
    assign mag        = r_speed[15] ? (~r_speed + 16'd1) : r_speed;
    assign flipped    = (r_speed == SpeedMin) ? SpeedMax : (~r_speed + 16'd1);
    assign prod       = 49'(r_d) * 49'(mag);
    assign adv_sat    = (|prod[48:40]) ? '1 : prod[39:8];
    assign lead_diff  = 34'(r_time) + 34'(r_delta) - 34'(r_lead_len);
    assign lead_short = r_lead_act & lead_diff[33];
    assign div_t      = {r_dr, r_dq[32]};
    assign div_ge     = (div_t >= len33);
    assign div_sub    = div_t - len33;
    assign is_final   = (r_loops != '0) && (r_wraps >= 34'(r_loops));
    assign fin_speed  = ((i_cfg.wrap_mode == WrapPing) && !r_loops[0]) ? flipped : r_speed;
    assign out_busy   = r_ovalid & ~o_rsp.ready;
    assign out_load   = (i_ctl.uop == UOP_RESULT) & ~out_busy;

    always_comb begin
        if (!r_load || r_lead_act) begin
            sample_val = '0;
        end else if (r_speed[15]) begin
            sample_val = (i_cfg.clip_length >= r_time) ? (i_cfg.clip_length - r_time) : '0;
        end else begin
            sample_val = r_time;
        end
    end

    always_comb begin
        o_flags.no_fire    = ~i_req.valid;
        o_flags.is_start   = (r_cmd == CmdStart);
        o_flags.tick_skip  = (r_cmd != CmdTick) | ~r_load | ~r_run;
        o_flags.lead_short = lead_short;
        o_flags.sum_lt     = (r_sum < len33);
        o_flags.div_more   = (r_cnt != DivLast);
        o_flags.not_final  = ~is_final;
        o_flags.start_zero = r_rpos | len_zero;
        o_flags.out_busy   = out_busy;
    end

    always_comb begin
        n_time     = r_time;
        n_lead_len = r_lead_len;
        n_lead_act = r_lead_act;
        n_run      = r_run;
        n_load     = r_load;
        n_ended    = r_ended;
        n_speed    = r_speed;
        n_loops    = r_loops;
        n_d        = r_d;
        n_adv      = r_adv;
        n_sum      = r_sum;
        n_rem      = r_rem;
        n_dq       = r_dq;
        n_dr       = r_dr;
        n_cnt      = r_cnt;
        n_wraps    = r_wraps;
        unique case (i_ctl.uop)
            UOP_NONE: begin
            end
            UOP_SIMPLE: begin
                n_ended = 1'b0;
                unique case (r_cmd)
                    CmdPause:  n_run = 1'b0;
                    CmdResume: n_run = 1'b1;
                    CmdClear: begin
                        n_time     = '0;
                        n_lead_len = '0;
                        n_lead_act = 1'b0;
                        n_run      = 1'b0;
                        n_load     = 1'b0;
                        n_speed    = '0;
                        n_loops    = '0;
                    end
                    default: begin
                    end
                endcase
            end
            UOP_LEAD: begin
                if (!r_lead_act) begin
                    n_d = {1'b0, r_delta};
                end else if (lead_short) begin
                    n_time = lead_diff[31:0] + r_lead_len;
                end else begin
                    n_d        = lead_diff[32:0];
                    n_time     = '0;
                    n_lead_act = 1'b0;
                    n_lead_len = '0;
                end
            end
            UOP_MUL:      n_adv = adv_sat;
            UOP_ADD:      n_sum = 33'(r_time) + 33'(r_adv);
            UOP_SUB:      n_rem = r_sum - len33;
            UOP_DIV_INIT: begin
                n_dq  = r_rem;
                n_dr  = '0;
                n_cnt = '0;
            end
            UOP_DIV_STEP: begin
                n_dr  = div_ge ? div_sub[31:0] : div_t[31:0];
                n_dq  = {r_dq[31:0], div_ge};
                n_cnt = r_cnt + t_cnt'(1);
            end
            UOP_WRAPS: n_wraps = len_zero ? 34'd1 : (34'(r_dq) + 34'd1);
            UOP_FINISH: begin
                n_speed = fin_speed;
                unique case (i_cfg.wrap_mode)
                    WrapNone: begin
                        n_time = '0;
                        n_load = 1'b0;
                    end
                    WrapOnce: n_time = '0;
                    WrapHold: n_time = i_cfg.clip_length;
                    WrapPing: n_time = fin_speed[15] ? '0 : i_cfg.clip_length;
                    default:  n_time = '0;
                endcase
                n_loops = '0;
                n_run   = 1'b0;
                n_ended = 1'b1;
            end
            UOP_APPLY: begin
                if (r_loops != '0) begin
                    n_loops = r_loops - r_wraps[15:0];
                end
                if ((i_cfg.wrap_mode == WrapPing) && r_wraps[0]) begin
                    n_speed = flipped;
                end
                n_time = len_zero ? '0 : r_dr;
            end
            UOP_SET_SUM: n_time = r_sum[31:0];
            UOP_START: begin
                if (i_cfg.lead_in_span != '0) begin
                    n_lead_act = 1'b1;
                    n_lead_len = i_cfg.lead_in_span;
                end
                n_load  = 1'b1;
                n_speed = i_cfg.start_speed;
                n_loops = i_cfg.start_loops;
                n_run   = 1'b1;
                n_dq    = {1'b0, r_time};
                n_dr    = '0;
                n_cnt   = '0;
            end
            UOP_TIME_REM: n_time = r_dr;
            UOP_TIME_CLR: n_time = '0;
            UOP_RESULT: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= '0;
            r_lead_len <= '0;
            r_lead_act <= 1'b0;
            r_run      <= 1'b0;
            r_load     <= 1'b0;
            r_ended    <= 1'b0;
            r_speed    <= '0;
            r_loops    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_time     <= n_time;
            r_lead_len <= n_lead_len;
            r_lead_act <= n_lead_act;
            r_run      <= n_run;
            r_load     <= n_load;
            r_ended    <= n_ended;
            r_speed    <= n_speed;
            r_loops    <= n_loops;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cmd   <= i_req.cmd;
            r_delta <= i_req.delta;
            r_rpos  <= i_req.reset_position;
        end
        r_d     <= n_d;
        r_adv   <= n_adv;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_dr    <= n_dr;
        r_cnt   <= n_cnt;
        r_wraps <= n_wraps;
        if (out_load) begin
            r_o_position <= r_time;
            r_o_sample   <= sample_val;
            r_o_playing  <= r_run;
            r_o_loaded   <= r_load;
            r_o_lead     <= r_lead_act;
            r_o_rev      <= r_speed[15];
            r_o_loops    <= r_loops;
            r_o_ended    <= r_ended;
        end
    end

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.position        = r_o_position;
    assign o_rsp.sample_point    = r_o_sample;
    assign o_rsp.is_playing      = r_o_playing;
    assign o_rsp.is_loaded       = r_o_loaded;
    assign o_rsp.in_lead_in      = r_o_lead;
    assign o_rsp.is_reversed     = r_o_rev;
    assign o_rsp.loops_remaining = r_o_loops;
    assign o_rsp.ended           = r_o_ended;

endmodule

`default_nettype wire

@@ hw/rtl/looping_playback_timer_top.sv @@
// Looping playback position timer for one clip channel: the top level.
// Uses i_req to take one command request (tick, start, pause, resume, clear)
// at a time and returns exactly one status result on o_rsp for each.
// Configuration (clip length, start speed, loop count, lead-in span, wrap
// mode) must be written by the user over the APB-style port only while no
// request is in flight; the block itself does not enforce this. The path
// from acceptance to result is shortest for pause, resume, clear, unused
// codes and skipped ticks, longer for ticks within the lead-in and for
// starts that restart at zero, longer still for ticks within the clip, and
// longest for ticks that wrap and starts that wrap the old position. A
// request is taken only while the sequencer waits at its idle step, so none
// is taken until the last result is registered. The restoring divider, one
// quotient bit a cycle, sets the long cases; it serves both the wrap count
// of a tick and the modulo of a start. Reset clears the channel state and
// the result valid flag, and the block waits idle with ready high. When the
// receiver stalls, the result stays in its register and the block takes one
// more request, which then waits at its final step until that register frees.
// Depends on lpt_pkg, lpt_if, lpt_cfg, lpt_seq and lpt_dp.
`default_nettype none

module looping_playback_timer_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lpt_req_if.sink         i_req,
    lpt_rsp_if.source       o_rsp,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  lpt_pkg::t_paddr i_paddr,
    input  lpt_pkg::t_pdata i_pwdata,
    output lpt_pkg::t_pdata o_prdata,
    output logic            o_pready
);
    import lpt_pkg::*;

    t_cfg   cfg;
    t_ctl   ctl;
    t_flags flags;

    lpt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    lpt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    lpt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctl   (ctl),
        .o_flags (flags),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lpt_chk.sv @@
// Port-level checker of the looping playback timer, bound to the top level.
// Depends on looping_playback_timer_top_macros.svh for the assertion macros.
`default_nettype none
`include "looping_playback_timer_top_macros.svh"

module lpt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_position,
    input logic [31:0] i_sample_point,
    input logic        i_is_playing,
    input logic        i_is_loaded,
    input logic        i_in_lead_in,
    input logic [15:0] i_loops_remaining,
    input logic        i_ended
);

    `LPT_ASSERT_RESET(a_reset_idle, i_clk, i_rst_n, !i_rsp_valid && i_req_ready)
    `LPT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_position) && $stable(i_ended))
    `LPT_ASSERT_NOW(a_end_stops, i_clk, i_rst_n, i_rsp_valid && i_ended, !i_is_playing && (i_loops_remaining == 16'd0))
    `LPT_ASSERT_NOW(a_no_sample, i_clk, i_rst_n, i_rsp_valid && (i_in_lead_in || !i_is_loaded), i_sample_point == 32'd0)

endmodule

bind looping_playback_timer_top lpt_chk u_lpt_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_position        (o_rsp.position),
    .i_sample_point    (o_rsp.sample_point),
    .i_is_playing      (o_rsp.is_playing),
    .i_is_loaded       (o_rsp.is_loaded),
    .i_in_lead_in      (o_rsp.in_lead_in),
    .i_loops_remaining (o_rsp.loops_remaining),
    .i_ended           (o_rsp.ended)
);

`default_nettype wire

@@ verif/lpt_status_checker.sv @@
// Status checker of the looping playback timer: snoops the register port and both
// channels, predicts the status for every accepted request and compares the results.
// Depends on lpt_pkg and lpt_if.
`default_nettype none

module lpt_status_checker
    import lpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    lpt_req_if     i_req,
    lpt_rsp_if     i_rsp,
    input  logic   i_psel,
    input  logic   i_penable,
    input  logic   i_pwrite,
    input  t_paddr i_paddr,
    input  t_pdata i_pwdata,
    input  logic   i_pready,
    output int     o_pending,
    output int     o_fail_count
);

    typedef struct packed {
        t_time  position;
        t_time  sample_point;
        logic   is_playing;
        logic   is_loaded;
        logic   in_lead_in;
        logic   is_reversed;
        t_loops loops_remaining;
        logic   ended;
    } t_status;

    t_time  clip_len;
    t_speed speed_cfg;
    t_loops loops_cfg;
    t_time  lead_span;
    t_wrap  wrap_cfg;

    t_time              play_pos;
    t_time              lead_len;
    logic               lead_on;
    logic               running;
    logic               loaded;
    logic signed [15:0] speed;
    t_loops             loops_left;

    t_status awaited_status[$];
    t_status want;
    t_status seen;
    int      mismatches;

    function automatic void clear_channel();
        play_pos   = '0;
        lead_len   = '0;
        lead_on    = 1'b0;
        running    = 1'b0;
        loaded     = 1'b0;
        speed      = '0;
        loops_left = '0;
    endfunction

    function automatic void reverse_speed();
        speed = (speed == $signed(SpeedMin)) ? $signed(SpeedMax) : -speed;
    endfunction

    function automatic void store_register(input t_regidx idx, input t_pdata val);
        case (idx)
            RegClipLength: clip_len = val;
            RegStartSpeed: speed_cfg = val[15:0];
            RegStartLoops: loops_cfg = val[15:0];
            RegLeadInSpan: lead_span = val;
            RegWrapMode:   wrap_cfg = val[1:0];
            default: ;
        endcase
    endfunction

    // Returns high when the final loop finishes on this tick.
    function automatic logic advance_position(input t_time delta);
        logic [63:0] span;
        logic [63:0] step;
        logic [63:0] len;
        logic [63:0] rest;
        logic [63:0] wraps;
        int          mag;
        if (!loaded || !running) begin
            return 1'b0;
        end
        span = 64'(delta);
        if (lead_on) begin
            if (64'(play_pos) + span >= 64'(lead_len)) begin
                span     = 64'(play_pos) + span - 64'(lead_len);
                play_pos = '0;
                lead_on  = 1'b0;
                lead_len = '0;
            end else begin
                play_pos = play_pos + delta;
                return 1'b0;
            end
        end
        mag = speed;
        if (mag < 0) begin
            mag = -mag;
        end
        step = (span * 64'(mag)) >> 8;
        if (step > 64'hFFFF_FFFF) begin
            step = 64'hFFFF_FFFF;
        end
        len = 64'(clip_len);
        if (64'(play_pos) + step < len) begin
            play_pos = t_time'(64'(play_pos) + step);
            return 1'b0;
        end
        rest  = 64'(play_pos) + step - len;
        wraps = (len == 0) ? 64'd1 : 64'd1 + rest / len;
        if (loops_left != 0 && wraps >= 64'(loops_left)) begin
            if (wrap_cfg == WrapPing && !loops_left[0]) begin
                reverse_speed();
            end
            case (wrap_cfg)
                WrapNone: begin
                    loaded   = 1'b0;
                    play_pos = '0;
                end
                WrapOnce: play_pos = '0;
                WrapHold: play_pos = clip_len;
                default:  play_pos = (speed >= 0) ? clip_len : '0;
            endcase
            loops_left = '0;
            running    = 1'b0;
            return 1'b1;
        end
        if (loops_left != 0) begin
            loops_left = loops_left - t_loops'(wraps);
        end
        if (wrap_cfg == WrapPing && wraps[0]) begin
            reverse_speed();
        end
        play_pos = (len == 0) ? '0 : t_time'(rest % len);
        return 1'b0;
    endfunction

    function automatic t_status predict_status(input t_cmd op, input t_time delta,
                                               input logic restart);
        t_status st;
        st.ended = 1'b0;
        case (op)
            CmdTick:  st.ended = advance_position(delta);
            CmdStart: begin
                if (lead_span != 0) begin
                    lead_on  = 1'b1;
                    lead_len = lead_span;
                end
                loaded     = 1'b1;
                speed      = speed_cfg;
                loops_left = loops_cfg;
                play_pos   = (restart || clip_len == 0) ? '0 : play_pos % clip_len;
                running    = 1'b1;
            end
            CmdPause:  running = 1'b0;
            CmdResume: running = 1'b1;
            CmdClear:  clear_channel();
            default: ;
        endcase
        if (!loaded || lead_on) begin
            st.sample_point = '0;
        end else if (speed < 0) begin
            st.sample_point = (clip_len >= play_pos) ? clip_len - play_pos : '0;
        end else begin
            st.sample_point = play_pos;
        end
        st.position        = play_pos;
        st.is_playing      = running;
        st.is_loaded       = loaded;
        st.in_lead_in      = lead_on;
        st.is_reversed     = speed < 0;
        st.loops_remaining = loops_left;
        return st;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %h, actual %h", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clip_len   = ClipLengthRst;
            speed_cfg  = StartSpeedRst;
            loops_cfg  = StartLoopsRst;
            lead_span  = LeadInSpanRst;
            wrap_cfg   = WrapModeRst;
            clear_channel();
            awaited_status.delete();
            mismatches = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                store_register(t_regidx'(i_paddr >> 2), i_pwdata);
            end
            if (i_req.valid && i_req.ready) begin
                awaited_status.push_back(predict_status(i_req.cmd, i_req.delta,
                                                        i_req.reset_position));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_status.size() == 0) begin
                    $error("Result arrived with no request outstanding.");
                    mismatches++;
                end else begin
                    want = awaited_status.pop_front();
                    seen.position        = i_rsp.position;
                    seen.sample_point    = i_rsp.sample_point;
                    seen.is_playing      = i_rsp.is_playing;
                    seen.is_loaded       = i_rsp.is_loaded;
                    seen.in_lead_in      = i_rsp.in_lead_in;
                    seen.is_reversed     = i_rsp.is_reversed;
                    seen.loops_remaining = i_rsp.loops_remaining;
                    seen.ended           = i_rsp.ended;
                    check_field("position", want.position, seen.position);
                    check_field("sample_point", want.sample_point, seen.sample_point);
                    check_field("is_playing", 32'(want.is_playing), 32'(seen.is_playing));
                    check_field("is_loaded", 32'(want.is_loaded), 32'(seen.is_loaded));
                    check_field("in_lead_in", 32'(want.in_lead_in), 32'(seen.in_lead_in));
                    check_field("is_reversed", 32'(want.is_reversed),
                                32'(seen.is_reversed));
                    check_field("loops_remaining", 32'(want.loops_remaining),
                                32'(seen.loops_remaining));
                    check_field("ended", 32'(want.ended), 32'(seen.ended));
                end
            end
        end
        o_pending    <= awaited_status.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

@@ verif/looping_playback_timer_top_test.sv @@
// Testbench top of the looping playback timer: clock, reset, register writes and
// command requests with random gaps, result stalls and the final verdict.
// Depends on lpt_pkg, lpt_if, lpt_status_checker and looping_playback_timer_top.
`default_nettype none

module looping_playback_timer_top_test;

    import lpt_pkg::*;

    localparam int CycleLimit  = 300000;
    localparam int LongHold    = 300;
    localparam int MaxGap      = 6;
    localparam int PhaseCount  = 10;
    localparam int PhaseItems  = 65;
    localparam int SettleLimit = 60;

    logic   i_clk;
    logic   i_rst_n;
    logic   apb_psel;
    logic   apb_penable;
    logic   apb_pwrite;
    t_paddr apb_paddr;
    t_pdata apb_pwdata;
    t_pdata apb_prdata;
    logic   apb_pready;
    int     pending;
    int     fail_count;
    int     cycles;
    bit     no_idle;
    bit     hold_due;

    t_time  cfg_clip;
    t_speed cfg_speed;

    lpt_req_if req_ch ();
    lpt_rsp_if rsp_ch ();

    looping_playback_timer_top u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_psel    (apb_psel),
        .i_penable (apb_penable),
        .i_pwrite  (apb_pwrite),
        .i_paddr   (apb_paddr),
        .i_pwdata  (apb_pwdata),
        .o_prdata  (apb_prdata),
        .o_pready  (apb_pready)
    );

    lpt_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_psel       (apb_psel),
        .i_penable    (apb_penable),
        .i_pwrite     (apb_pwrite),
        .i_paddr      (apb_paddr),
        .i_pwdata     (apb_pwdata),
        .i_pready     (apb_pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : result_drain
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        rsp_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                gap = no_idle ? 0 : $urandom_range(0, MaxGap);
                if (hold_due) begin
                    gap      = LongHold;
                    hold_due = 1'b0;
                end
                if (gap > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_request(input t_cmd op, input t_time delta, input logic restart);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= op;
        req_ch.delta          <= delta;
        req_ch.reset_position <= restart;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_regidx idx, input t_pdata val);
        apb_psel    <= 1'b1;
        apb_penable <= 1'b0;
        apb_pwrite  <= 1'b1;
        apb_paddr   <= t_paddr'({idx, 2'b00});
        apb_pwdata  <= val;
        @(posedge i_clk);
        apb_penable <= 1'b1;
        do @(posedge i_clk); while (!apb_pready);
    endtask

    task automatic configure(input t_time clip, input t_speed speed, input t_loops loops,
                             input t_time lead, input t_wrap wrap);
        settle();
        apb_write(RegClipLength, clip);
        apb_write(RegStartSpeed, t_pdata'(speed));
        apb_write(RegStartLoops, t_pdata'(loops));
        apb_write(RegLeadInSpan, lead);
        apb_write(RegWrapMode, t_pdata'(wrap));
        apb_psel    <= 1'b0;
        apb_penable <= 1'b0;
        cfg_clip  = clip;
        cfg_speed = speed;
    endtask

    // Most deltas are scaled so that one tick covers a fraction to a few clip lengths.
    function automatic t_time pick_delta();
        logic [63:0] unit;
        int          mag;
        int          sel;
        mag = $signed(cfg_speed);
        if (mag < 0) begin
            mag = -mag;
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            return '0;
        end
        if (sel == 1) begin
            return '1;
        end
        if (sel < 4) begin
            return t_time'($urandom);
        end
        if (sel < 6 || mag == 0) begin
            return t_time'($urandom_range(0, 32'h0002_0000));
        end
        unit = (64'(cfg_clip) << 8) / 64'(mag);
        unit = (unit * 64'($urandom_range(0, 12))) >> 2;
        return (unit > 64'hFFFF_FFFF) ? '1 : unit[31:0];
    endfunction

    task automatic run_phase(input int n_items);
        int done;
        int sel;
        done = 0;
        while (done < n_items) begin
            send_request(CmdStart, t_time'($urandom), 1'($urandom_range(0, 1)));
            done++;
            repeat ($urandom_range(2, 10)) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    send_request(CmdTick, pick_delta(), 1'($urandom_range(0, 1)));
                end else if (sel < 88) begin
                    send_request(CmdPause, t_time'($urandom), 1'($urandom_range(0, 1)));
                end else if (sel < 95) begin
                    send_request(CmdResume, t_time'($urandom), 1'($urandom_range(0, 1)));
                end else if (sel < 98) begin
                    send_request(CmdClear, t_time'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    send_request(t_cmd'($urandom_range(5, 7)), t_time'($urandom),
                                 1'($urandom_range(0, 1)));
                end
                done++;
            end
        end
    endtask

    initial begin : stimulus
        int     p;
        int     sel;
        t_time  clip;
        t_speed speed;
        t_loops loops;
        t_time  lead;
        t_wrap  wrap;
        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.cmd            <= CmdTick;
        req_ch.delta          <= '0;
        req_ch.reset_position <= 1'b0;
        apb_psel              <= 1'b0;
        apb_penable           <= 1'b0;
        apb_pwrite            <= 1'b0;
        apb_paddr             <= '0;
        apb_pwdata            <= '0;
        no_idle   = 1'b0;
        hold_due  = 1'b0;
        cfg_clip  = ClipLengthRst;
        cfg_speed = StartSpeedRst;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CmdTick, '1, 1'b1);
        send_request(CmdResume, '0, 1'b0);
        send_request(CmdTick, 32'h1234_5678, 1'b0);
        send_request(CmdPause, '0, 1'b0);
        send_request(CmdStart, '0, 1'b1);
        send_request(CmdTick, '0, 1'b0);
        send_request(t_cmd'(5), '0, 1'b0);
        send_request(t_cmd'(6), '0, 1'b0);
        send_request(t_cmd'(7), '1, 1'b1);
        send_request(CmdClear, '0, 1'b0);

        configure(32'h0003_0000, SpeedMin, 16'd3, 32'h0000_8000, WrapPing);
        send_request(CmdStart, '0, 1'b0);
        send_request(CmdTick, 32'h0000_4000, 1'b0);
        send_request(CmdTick, 32'h0000_6000, 1'b0);
        send_request(CmdStart, '0, 1'b1);
        send_request(CmdTick, '1, 1'b0);

        configure(32'h0003_0000, SpeedMax, 16'hFFFF, 32'h0001_0000, WrapHold);
        send_request(CmdStart, '0, 1'b1);
        configure(32'h0003_0000, SpeedMax, 16'hFFFF, 32'd0, WrapHold);
        send_request(CmdStart, '0, 1'b0);
        send_request(CmdTick, 32'h0000_8000, 1'b0);
        send_request(CmdTick, 32'h0001_0000, 1'b0);
        send_request(CmdPause, '0, 1'b0);
        send_request(CmdTick, 32'h0001_0000, 1'b0);
        send_request(CmdResume, '0, 1'b0);
        send_request(CmdTick, 32'h0000_0100, 1'b0);

        configure('1, 16'h0100, 16'd1, 32'd0, WrapNone);
        send_request(CmdStart, '0, 1'b1);
        send_request(CmdTick, '1, 1'b0);

        for (p = 0; p < PhaseCount; p++) begin
            sel  = $urandom_range(0, 7);
            clip = (sel == 0) ? 32'd0 : (sel == 1) ? '1 :
                   t_time'($urandom_range(1, 32'h0008_0000));
            sel = $urandom_range(0, 7);
            case (sel)
                0: speed = SpeedMin;
                1: speed = SpeedMax;
                2: speed = 16'd0;
                3: speed = 16'h0100;
                4: speed = 16'hFF00;
                default: speed = t_speed'($urandom);
            endcase
            loops = ($urandom_range(0, 7) == 0) ? 16'hFFFF : t_loops'($urandom_range(0, 6));
            lead  = ($urandom_range(0, 3) == 0) ?
                    t_time'($urandom_range(1, 32'h0002_0000)) : 32'd0;
            wrap  = t_wrap'($urandom_range(0, 3));
            if (p == 1) begin
                clip  = '1;
                speed = SpeedMin;
                loops = '1;
                lead  = '1;
                wrap  = WrapHold;
            end
            if (p == 2) begin
                clip  = '0;
                speed = SpeedMax;
                loops = '0;
                lead  = '0;
                wrap  = WrapNone;
            end
            configure(clip, speed, loops, lead, wrap);
            no_idle  = (p % 4 == 3);
            hold_due = (p == 4);
            run_phase(PhaseItems);
        end

        settle();
        repeat (SettleLimit) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lpt_pkg.sv
hw/rtl/lpt_if.sv
hw/rtl/lpt_cfg.sv
hw/rtl/lpt_seq.sv
hw/rtl/lpt_dp.sv
hw/rtl/looping_playback_timer_top.sv
hw/rtl/lpt_chk.sv
verif/lpt_status_checker.sv
verif/looping_playback_timer_top_test.sv
